/* hw/rtl/box_smooth_3d_27pt_macros.svh */
// assertion macros shared by the box smoothing rtl
`ifndef BOX_SMOOTH_3D_27PT_MACROS_SVH
`define BOX_SMOOTH_3D_27PT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BS27_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent at one edge, consequent at the next edge
`define BS27_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bs27_pkg.sv */
// shared constants and types of the 27-point box smoothing block
package bs27_pkg;

  // configuration register geometry
  localparam int unsigned SIZE_BITS     = 8;
  localparam int unsigned SIZE_CAP      = 254;
  localparam int unsigned ADDR_BITS     = 4;
  localparam int unsigned DATA_BITS     = 32;

  // rounded mean: floor((sum + ROUND_BIAS) / DIVISOR)
  localparam int unsigned DIVISOR       = 27;
  localparam int unsigned ROUND_BIAS    = 13;

  // result queue
  localparam int unsigned FIFO_DEPTH    = 16;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_e;

  // control that travels alongside a sum through the rounding pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

/* hw/rtl/bs27_round.sv */
// pipelined rounded division of a 27-sample sum by 27
module bs27_round #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS+4:0] sum_i,
  input  bs27_pkg::tag_t                tag_i,
  output logic signed [SAMPLE_BITS-1:0] smoothed_o,
  output bs27_pkg::tag_t                tag_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned EW  = SB + 6;       // extended width for the offset add
  localparam int unsigned W   = SB + 5;       // offset sum, always non-negative
  localparam int unsigned MW  = W - 4;        // reciprocal width
  localparam int unsigned H   = W / 2;        // low half of the split multiply
  localparam int unsigned HW  = W - H;        // high half width
  localparam int unsigned PHW = HW + MW;
  localparam int unsigned PLW = H + MW;
  localparam int unsigned PW  = W + MW;

  // bias that makes the dividend non-negative and rounds to nearest
  localparam longint OFFSET_VAL = longint'(bs27_pkg::ROUND_BIAS)
                                + longint'(bs27_pkg::DIVISOR) * (longint'(1) << (SB - 1));
  localparam logic [EW-1:0] OFFSET = EW'(OFFSET_VAL);
  // floor(2^W / 27), quotient estimate is exact or one low
  localparam logic [MW-1:0] RECIP  = MW'((64'd1 << W) / 64'(bs27_pkg::DIVISOR));

  bs27_pkg::tag_t tag_a_q, tag_b_q, tag_c_q, tag_o_q;
  logic [W-1:0]   t_a_q, t_b_q, t_c_q;
  logic [PHW-1:0] ph_q;
  logic [PLW-1:0] pl_q;
  logic [SB-1:0]  q0_c_q;
  logic signed [SB-1:0] smoothed_q;

  logic [EW-1:0]  t_ext;
  logic [PW-1:0]  prod;
  logic [W-1:0]   rem;
  logic [SB-1:0]  quot;

  // stage a: biased dividend
  assign t_ext = EW'(sum_i) + OFFSET;

  // stage c: combine partial products
  assign prod = (PW'(ph_q) << H) + PW'(pl_q);

  // stage d: remainder check and one-step correction
  assign rem  = t_c_q - W'(q0_c_q) * W'(bs27_pkg::DIVISOR);
  assign quot = (rem >= W'(bs27_pkg::DIVISOR)) ? q0_c_q + 1'b1 : q0_c_q;

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
      tag_o_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
      tag_o_q <= tag_c_q;
    end
  end

  // data pipeline
  always_ff @(posedge clk_i) begin
    t_a_q      <= t_ext[W-1:0];
    ph_q       <= PHW'(t_a_q[W-1:H]) * PHW'(RECIP);
    pl_q       <= PLW'(t_a_q[H-1:0]) * PLW'(RECIP);
    t_b_q      <= t_a_q;
    q0_c_q     <= prod[W+SB-1:W];
    t_c_q      <= t_b_q;
    // quotient is offset by half the range: flip the sign bit
    smoothed_q <= signed'({~quot[SB-1], quot[SB-2:0]});
  end

  assign smoothed_o = smoothed_q;
  assign tag_o      = tag_o_q;

endmodule

/* hw/rtl/box_smooth_3d_27pt.sv */
// top level of the streaming 3x3x3 box smoothing block
//
// Samples of the padded grid arrive on sample_i with valid/ready, one request
// per item, x slowest, then y, then z fastest. The block emits one result for
// every interior point, on the request that carries the neighbour at (+1,+1,+1);
// border samples give none. last_point_o marks the final interior point.
// size_x, size_y and size_z are set through the APB port (byte addresses 0, 4
// and 8); any write to them restarts the grid at its first sample.
//
// Throughput is one sample per cycle: each sample does one read-modify-write of
// the plane memory (two past planes per y,z) and one of the line memory (two
// past column sums per z). result_valid_o rises once the sum has passed stages
// 1 to 3, the rounding divider and the queue count. Results queue in a 16-entry
// buffer; sample_ready_o drops only when that many results are pending or in
// flight, so a stalled receiver holds off the sender without losing anything.
// Reset clears the sizes to 1, the grid position and the queue. The memories
// need no clearing: every entry read for a result was written earlier in the
// same grid.
module box_smooth_3d_27pt #(
  parameter int unsigned MAX_SIZE_Y  = 254,
  parameter int unsigned MAX_SIZE_Z  = 254,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample channel
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  // result channel
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        smoothed_o,
  output logic                                 last_point_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bs27_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [bs27_pkg::DATA_BITS-1:0]       pwdata,
  output logic [bs27_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);

`include "box_smooth_3d_27pt_macros.svh"

  localparam int unsigned SB        = SAMPLE_BITS;
  localparam int unsigned SZW       = bs27_pkg::SIZE_BITS;
  localparam int unsigned EFF_MAX_Y = (MAX_SIZE_Y < bs27_pkg::SIZE_CAP) ?
                                      MAX_SIZE_Y : bs27_pkg::SIZE_CAP;
  localparam int unsigned EFF_MAX_Z = (MAX_SIZE_Z < bs27_pkg::SIZE_CAP) ?
                                      MAX_SIZE_Z : bs27_pkg::SIZE_CAP;
  localparam int unsigned YW        = $clog2(EFF_MAX_Y + 2);
  localparam int unsigned ZW        = $clog2(EFF_MAX_Z + 2);
  localparam int unsigned PLANE_D   = (EFF_MAX_Y + 2) * (EFF_MAX_Z + 2);
  localparam int unsigned PAW       = $clog2(PLANE_D);
  localparam int unsigned LINE_D    = EFF_MAX_Z + 2;
  localparam int unsigned CXW       = SB + 2;   // sum of 3 samples
  localparam int unsigned CYW       = SB + 4;   // sum of 9 samples
  localparam int unsigned SW        = SB + 5;   // sum of 27 samples
  localparam int unsigned PTRW      = bs27_pkg::FIFO_PTR_BITS;
  localparam int unsigned CNTW      = PTRW + 1;
  localparam int unsigned AW        = bs27_pkg::ADDR_BITS;

  // configuration registers
  logic [SZW-1:0] size_x_q, size_y_q, size_z_q;
  logic [SZW-1:0] size_x_d, size_y_d, size_z_d;
  logic           cfg_we, cfg_restart;
  logic [1:0]     cfg_idx;

  // grid position
  logic [SZW-1:0] pos_x_q, pos_x_d;
  logic [YW-1:0]  pos_y_q, pos_y_d;
  logic [ZW-1:0]  pos_z_q, pos_z_d;
  logic [PAW-1:0] plane_addr_q, plane_addr_d;
  logic [SZW-1:0] eff_x, eff_y, eff_z, lim_x;
  logic [YW-1:0]  lim_y;
  logic [ZW-1:0]  lim_z;
  logic           accept, emit, last;

  // memories
  logic [2*SB-1:0]  plane_mem [PLANE_D];
  logic [2*CXW-1:0] line_mem  [LINE_D];
  logic [2*SB-1:0]  plane_rd_q;
  logic [2*CXW-1:0] line_rd_q;

  // pipeline stages
  logic                  v_q1, v_q2;
  logic                  emit_q1, last_q1, emit_q2, last_q2;
  logic signed [SB-1:0]  sample_q1;
  logic [PAW-1:0]        paddr_q1;
  logic [ZW-1:0]         z_q1, z_q2;
  logic signed [CXW-1:0] cx_q2;
  logic signed [CYW-1:0] cy_q3, d1_q3, d2_q3, zs1_q, zs2_q;
  logic signed [SW-1:0]  sum_q4;
  bs27_pkg::tag_t        tag_q3, tag_q4, round_tag;
  logic signed [SB-1:0]  round_smoothed;

  logic signed [SB-1:0]  p_new, p_old;
  logic signed [CXW-1:0] cx, l_new, l_old;
  logic signed [CYW-1:0] cy;

  // result queue
  logic [SB:0]     fifo_q [bs27_pkg::FIFO_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] fifo_cnt_q, occ_q;
  logic            push, pop;

  // apb port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[AW-1:2];

  always_comb begin
    size_x_d    = size_x_q;
    size_y_d    = size_y_q;
    size_z_d    = size_z_q;
    cfg_restart = 1'b0;
    prdata      = '0;
    case (bs27_pkg::reg_idx_e'(cfg_idx))
      bs27_pkg::REG_SIZE_X: begin
        prdata      = bs27_pkg::DATA_BITS'(size_x_q);
        size_x_d    = cfg_we ? pwdata[SZW-1:0] : size_x_q;
        cfg_restart = cfg_we;
      end
      bs27_pkg::REG_SIZE_Y: begin
        prdata      = bs27_pkg::DATA_BITS'(size_y_q);
        size_y_d    = cfg_we ? pwdata[SZW-1:0] : size_y_q;
        cfg_restart = cfg_we;
      end
      bs27_pkg::REG_SIZE_Z: begin
        prdata      = bs27_pkg::DATA_BITS'(size_z_q);
        size_z_d    = cfg_we ? pwdata[SZW-1:0] : size_z_q;
        cfg_restart = cfg_we;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // sizes clamped to the supported range, and the last padded index
  always_comb begin
    if (size_x_q == '0) begin
      eff_x = SZW'(1);
    end else if (size_x_q > SZW'(bs27_pkg::SIZE_CAP)) begin
      eff_x = SZW'(bs27_pkg::SIZE_CAP);
    end else begin
      eff_x = size_x_q;
    end
    if (size_y_q == '0) begin
      eff_y = SZW'(1);
    end else if (size_y_q > SZW'(EFF_MAX_Y)) begin
      eff_y = SZW'(EFF_MAX_Y);
    end else begin
      eff_y = size_y_q;
    end
    if (size_z_q == '0) begin
      eff_z = SZW'(1);
    end else if (size_z_q > SZW'(EFF_MAX_Z)) begin
      eff_z = SZW'(EFF_MAX_Z);
    end else begin
      eff_z = size_z_q;
    end
    lim_x = eff_x + 1'b1;
    lim_y = YW'({1'b0, eff_y} + 9'd1);
    lim_z = ZW'({1'b0, eff_z} + 9'd1);
  end

  // request handshake and result classification
  assign sample_ready_o = (occ_q < CNTW'(bs27_pkg::FIFO_DEPTH));
  assign accept         = sample_valid_i && sample_ready_o;
  assign emit           = (pos_x_q >= SZW'(2)) && (pos_y_q >= YW'(2)) && (pos_z_q >= ZW'(2));
  assign last           = (pos_x_q == lim_x) && (pos_y_q == lim_y) && (pos_z_q == lim_z);

  // raster position and plane memory address
  always_comb begin
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    pos_z_d      = pos_z_q;
    plane_addr_d = plane_addr_q;
    if (cfg_restart) begin
      pos_x_d      = '0;
      pos_y_d      = '0;
      pos_z_d      = '0;
      plane_addr_d = '0;
    end else if (accept) begin
      if (pos_z_q == lim_z) begin
        pos_z_d = '0;
        if (pos_y_q == lim_y) begin
          pos_y_d      = '0;
          plane_addr_d = '0;
          pos_x_d      = (pos_x_q == lim_x) ? '0 : pos_x_q + 1'b1;
        end else begin
          pos_y_d      = pos_y_q + 1'b1;
          plane_addr_d = plane_addr_q + 1'b1;
        end
      end else begin
        pos_z_d      = pos_z_q + 1'b1;
        plane_addr_d = plane_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q     <= SZW'(1);
      size_y_q     <= SZW'(1);
      size_z_q     <= SZW'(1);
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      pos_z_q      <= '0;
      plane_addr_q <= '0;
    end else begin
      size_x_q     <= size_x_d;
      size_y_q     <= size_y_d;
      size_z_q     <= size_z_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      pos_z_q      <= pos_z_d;
      plane_addr_q <= plane_addr_d;
    end
  end

  // stage valids, reset as control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q1   <= 1'b0;
      v_q2   <= 1'b0;
      tag_q3 <= '0;
      tag_q4 <= '0;
    end else begin
      v_q1         <= accept;
      v_q2         <= v_q1;
      tag_q3.valid <= v_q2 && emit_q2;
      tag_q3.last  <= last_q2;
      tag_q4       <= tag_q3;
    end
  end

  // plane memory: read at accept, written back in the next cycle; the same y,z
  // entry comes round again only after at least nine samples, so no overlap
  always_ff @(posedge clk_i) begin
    if (accept) begin
      plane_rd_q <= plane_mem[plane_addr_q];
    end
    if (v_q1) begin
      plane_mem[paddr_q1] <= {p_new, sample_q1};
    end
  end

  // stage 1: sum along x
  assign p_new = signed'(plane_rd_q[SB-1:0]);
  assign p_old = signed'(plane_rd_q[2*SB-1:SB]);
  assign cx    = CXW'(sample_q1) + CXW'(p_new) + CXW'(p_old);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q1 <= sample_i;
      paddr_q1  <= plane_addr_q;
      z_q1      <= pos_z_q;
      emit_q1   <= emit;
      last_q1   <= last;
    end
    if (v_q1) begin
      cx_q2   <= cx;
      z_q2    <= z_q1;
      emit_q2 <= emit_q1;
      last_q2 <= last_q1;
    end
  end

  // line memory: read in stage 1, write back in stage 2; a z entry repeats
  // only after at least three samples
  always_ff @(posedge clk_i) begin
    if (v_q1) begin
      line_rd_q <= line_mem[z_q1];
    end
    if (v_q2) begin
      line_mem[z_q2] <= {l_new, cx_q2};
    end
  end

  // stage 2: sum along y, then shift along z
  assign l_new = signed'(line_rd_q[CXW-1:0]);
  assign l_old = signed'(line_rd_q[2*CXW-1:CXW]);
  assign cy    = CYW'(cx_q2) + CYW'(l_new) + CYW'(l_old);

  always_ff @(posedge clk_i) begin
    if (v_q2) begin
      zs1_q <= cy;
      zs2_q <= zs1_q;
      cy_q3 <= cy;
      d1_q3 <= zs1_q;
      d2_q3 <= zs2_q;
    end
    // stage 3: sum along z
    sum_q4 <= SW'(cy_q3) + SW'(d1_q3) + SW'(d2_q3);
  end

  // rounding divide by 27
  bs27_round #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sum_i     (sum_q4),
    .tag_i     (tag_q4),
    .smoothed_o(round_smoothed),
    .tag_o     (round_tag)
  );

  // result queue, space reserved at accept
  assign push           = round_tag.valid;
  assign pop            = result_valid_o && result_ready_i;
  assign result_valid_o = (fifo_cnt_q != '0);
  assign smoothed_o     = signed'(fifo_q[rd_ptr_q][SB-1:0]);
  assign last_point_o   = fifo_q[rd_ptr_q][SB];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {round_tag.last, round_smoothed};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      occ_q      <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_q + CNTW'(push) - CNTW'(pop);
      occ_q      <= occ_q + CNTW'(accept && emit) - CNTW'(pop);
    end
  end

  // checks
  `BS27_ASSERT(occ_bound_a, occ_q <= CNTW'(bs27_pkg::FIFO_DEPTH), "reservations exceed queue")
  `BS27_ASSERT(cnt_le_occ_a, fifo_cnt_q <= occ_q, "queued results without reservation")
  `BS27_ASSERT(push_room_a, push |-> (fifo_cnt_q < CNTW'(bs27_pkg::FIFO_DEPTH) || pop), "queue overflow")
  `BS27_ASSERT_NEXT(cfg_restart_a, cfg_restart, pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0 && plane_addr_q == '0, "register write did not restart grid")

endmodule

/* tb/testbench.sv */
// self-checking testbench for the 27-point 3d box smoothing block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SMP_BITS       = 16;
  localparam int unsigned EDGE_CAP       = 254;
  localparam int unsigned SPAN           = EDGE_CAP + 2;
  localparam int unsigned LIMIT_CYCLES   = 1_000_000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_SAMPLES = 500;
  localparam int unsigned SHORT_GRID     = 200;

  typedef logic signed [SMP_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t smoothed;
    logic    last_point;
  } point_t;

  // how the samples of one grid are chosen
  typedef enum logic [2:0] {
    FILL_RANDOM,
    FILL_MAX,
    FILL_MIN,
    FILL_EDGES,
    FILL_NEAR
  } fill_e;

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           sample_valid_i = 1'b0;
  logic                           sample_ready_o;
  sample_t                        sample_i       = '0;
  logic                           result_valid_o;
  logic                           result_ready_i = 1'b0;
  sample_t                        smoothed_o;
  logic                           last_point_o;
  logic                           psel           = 1'b0;
  logic                           penable        = 1'b0;
  logic                           pwrite         = 1'b0;
  logic [bs27_pkg::ADDR_BITS-1:0] paddr          = '0;
  logic [bs27_pkg::DATA_BITS-1:0] pwdata         = '0;
  logic [bs27_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  box_smooth_3d_27pt u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .smoothed_o     (smoothed_o),
    .last_point_o   (last_point_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // grid samples waiting to be offered, and means waiting to come out
  sample_t     feed_q[$];
  point_t      mean_q[$];

  // shadow of the block: sizes, grid position and the three rotating planes
  logic [7:0]  cfg_size [3];
  int unsigned pos_x, pos_y, pos_z;
  shortint     plane_mem [3][SPAN][SPAN];

  bit          sample_taken   = 1'b0;
  bit          recv_hold      = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned n_errors       = 0;
  int unsigned n_samples      = 0;
  int unsigned n_points       = 0;
  int unsigned n_pushed       = 0;
  int unsigned n_grids        = 0;
  int unsigned n_writes       = 0;

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(logic [7:0] v);
    if (v == 0) return 1;
    if (v > EDGE_CAP) return EDGE_CAP;
    return v;
  endfunction

  function automatic int unsigned grid_len();
    return (eff_size(cfg_size[bs27_pkg::REG_SIZE_X]) + 2) *
           (eff_size(cfg_size[bs27_pkg::REG_SIZE_Y]) + 2) *
           (eff_size(cfg_size[bs27_pkg::REG_SIZE_Z]) + 2);
  endfunction

  // store one sample and, once its neighborhood is complete, queue the rounded mean
  function automatic void smooth_sample(sample_t s);
    int unsigned ex, ey, ez;
    longint      acc, num, q;
    point_t      pt;
    ex = eff_size(cfg_size[bs27_pkg::REG_SIZE_X]);
    ey = eff_size(cfg_size[bs27_pkg::REG_SIZE_Y]);
    ez = eff_size(cfg_size[bs27_pkg::REG_SIZE_Z]);
    plane_mem[pos_x % 3][pos_y][pos_z] = s;
    if (pos_x >= 2 && pos_y >= 2 && pos_z >= 2) begin
      acc = 0;
      for (int unsigned a = pos_x - 2; a <= pos_x; a++)
        for (int unsigned b = pos_y - 2; b <= pos_y; b++)
          for (int unsigned c = pos_z - 2; c <= pos_z; c++)
            acc += plane_mem[a % 3][b][c];
      // floor((2*sum + 27) / 54), division truncates toward zero
      num = 2 * acc + 27;
      q = num / 54;
      if (num < 0 && q * 54 != num) q -= 1;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      pt.smoothed   = sample_t'(q);
      pt.last_point = (pos_x == ex + 1 && pos_y == ey + 1 && pos_z == ez + 1);
      mean_q.push_back(pt);
    end
    // z fastest, then y, then x; wrap to the next grid
    pos_z++;
    if (pos_z > ez + 1) begin
      pos_z = 0;
      pos_y++;
      if (pos_y > ey + 1) begin
        pos_y = 0;
        pos_x++;
        if (pos_x > ex + 1) pos_x = 0;
      end
    end
  endfunction

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // sample driver: holds a request until it is taken; also drives result_ready_i
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!sample_valid_i || sample_taken) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_valid_i <= 1'b1;
          sample_i       <= feed_q.pop_front();
        end else begin
          sample_valid_i <= 1'b0;
        end
      end
      sample_taken = 1'b0;
      result_ready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted samples, check accepted results
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni) begin
      if (sample_valid_i && sample_ready_o) begin
        smooth_sample(sample_i);
        sample_taken = 1'b1;
        n_samples++;
      end
      if (result_valid_o && result_ready_i) begin
        n_points++;
        if (mean_q.size() == 0) begin
          flag_error($sformatf("unexpected result smoothed=%0d last=%0b",
                               smoothed_o, last_point_o));
        end else begin
          want = mean_q.pop_front();
          if (smoothed_o !== want.smoothed || last_point_o !== want.last_point)
            flag_error($sformatf("point %0d: smoothed exp %0d got %0d, last exp %0b got %0b",
                                 n_points, want.smoothed, smoothed_o, want.last_point,
                                 last_point_o));
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, mean_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
    end
  end

  // wait until nothing is pending, then let the pipeline empty
  task automatic settle();
    while (feed_q.size() != 0 || sample_valid_i || mean_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(bs27_pkg::reg_idx_e idx, logic [7:0] val);
    logic [31:0] junk;
    junk = $urandom;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:8], val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // any write restarts the grid
    cfg_size[idx] = val;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    n_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_sizes(logic [7:0] sx, logic [7:0] sy, logic [7:0] sz);
    settle();
    reg_write(bs27_pkg::REG_SIZE_X, sx);
    reg_write(bs27_pkg::REG_SIZE_Y, sy);
    reg_write(bs27_pkg::REG_SIZE_Z, sz);
  endtask

  function automatic sample_t pick_value(fill_e f);
    case (f)
      FILL_MAX:   return sample_t'(16'sh7fff);
      FILL_MIN:   return sample_t'(16'sh8000);
      FILL_EDGES: return $urandom_range(1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
      FILL_NEAR:  return sample_t'(int'($urandom_range(60)) - 30);
      default:    return sample_t'($urandom);
    endcase
  endfunction

  task automatic load_grid(int unsigned count, fill_e f);
    for (int unsigned i = 0; i < count; i++) feed_q.push_back(pick_value(f));
    n_pushed += count;
  endtask

  function automatic fill_e rand_fill();
    case ($urandom_range(9))
      0:       return FILL_MAX;
      1:       return FILL_MIN;
      2, 3:    return FILL_EDGES;
      4:       return FILL_NEAR;
      default: return FILL_RANDOM;
    endcase
  endfunction

  function automatic logic [7:0] rand_size();
    case ($urandom_range(19))
      0:       return 8'd0;
      1:       return 8'($urandom_range(5, 6));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  // idling modes: none, sender mostly idle, receiver mostly stalled, light on both
  task automatic set_idling(int unsigned k);
    case (k % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  // stimulus
  initial begin
    int unsigned rand_start, total, cut;
    bit          restart;
    cfg_size[bs27_pkg::REG_SIZE_X] = 8'd1;
    cfg_size[bs27_pkg::REG_SIZE_Y] = 8'd1;
    cfg_size[bs27_pkg::REG_SIZE_Z] = 8'd1;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset sizes: one point per grid, saturated both ways, then wrap to a new grid
    load_grid(grid_len(), FILL_MAX);
    load_grid(grid_len(), FILL_MIN);
    n_grids += 2;

    // extreme sizes along each axis, with zero and above-cap values, cut short
    set_idling(0);
    set_sizes(8'd255, 8'd0, 8'd1);
    load_grid(SHORT_GRID, FILL_EDGES);
    set_idling(1);
    set_sizes(8'd1, 8'd254, 8'd0);
    load_grid(SHORT_GRID, FILL_RANDOM);
    set_idling(3);
    set_sizes(8'd0, 8'd1, 8'd255);
    load_grid(SHORT_GRID, FILL_RANDOM);
    n_grids += 3;

    // long receiver hold-off while the sender keeps offering
    set_sizes(8'd3, 8'd3, 8'd3);
    set_idling(0);
    load_grid(grid_len(), FILL_RANDOM);
    n_grids++;
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    recv_hold = 1'b0;
    settle();

    // random grids: mostly whole, some cut short and restarted, some paused midway
    rand_start = n_pushed;
    restart = 1'b1;
    while (n_pushed - rand_start < RANDOM_SAMPLES) begin
      set_idling($urandom_range(3));
      if (restart || $urandom_range(3) != 0) begin
        if ($urandom_range(3) == 0 && !restart) begin
          settle();
          reg_write(bs27_pkg::reg_idx_e'($urandom_range(2)), rand_size());
        end else begin
          set_sizes(rand_size(), rand_size(), rand_size());
        end
      end
      total = grid_len();
      restart = 1'b0;
      case ($urandom_range(7))
        0: begin
          cut = $urandom_range(1, total - 1);
          load_grid(cut, rand_fill());
          restart = 1'b1;
          settle();
        end
        1: begin
          cut = total / 2;
          load_grid(cut, rand_fill());
          settle();
          load_grid(total - cut, rand_fill());
        end
        default: load_grid(total, rand_fill());
      endcase
      n_grids++;
    end

    settle();
    $display("checked %0d smoothed points from %0d samples over %0d grids, %0d register writes",
             n_points, n_samples, n_grids, n_writes);
    $display("sizes 0 to 255 on every axis, saturated grids, restarts mid-grid, all idle modes");
    if (n_errors == 0 && mean_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, mean_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
